### rtl/affine_residual_norm_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef AFFINE_RESIDUAL_NORM_DEFINES_SVH
`define AFFINE_RESIDUAL_NORM_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define ARN_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define ARN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/arn_pkg.sv
package arn_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned PROD_W   = COEF_W + COORD_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned TERM_W   = PROD_W - FRAC_W;
  localparam int unsigned OFS_W    = COORD_W + 1;
  localparam int unsigned SUM_W    = TERM_W + 2;
  localparam int unsigned SQ_W     = 2 * COORD_W;

  localparam int unsigned ROOT_STEPS      = SQ_W / 2;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;
  localparam int unsigned ROOT_TOP        = SQ_W - 2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_M00     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M01     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M10     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M11     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd5;

  localparam logic signed [COEF_W-1:0]  COEF_ONE  = 32'sd65536;
  localparam logic signed [COEF_W-1:0]  COEF_ZERO = 32'sd0;
  localparam logic signed [COORD_W-1:0] SHIFT_RST = 24'sd0;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 42'sd8388607;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -42'sd8388608;

  // One queued correspondence: the four truncated products and the
  // combined offset (translation minus target) for each axis.
  typedef struct packed {
    logic signed [TERM_W-1:0] p00;
    logic signed [TERM_W-1:0] p01;
    logic signed [TERM_W-1:0] p10;
    logic signed [TERM_W-1:0] p11;
    logic signed [OFS_W-1:0]  ox;
    logic signed [OFS_W-1:0]  oy;
    logic                     last;
  } arn_pair_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } arn_root_t;

  // One step of the digit-by-digit square root; k counts from the top.
  function automatic arn_root_t root_step(arn_root_t s, int unsigned k);
    logic [SQ_W-1:0] b;
    logic [SQ_W:0]   trial;
    arn_root_t       r;
    b     = SQ_W'(1) << (ROOT_TOP - 2 * k);
    trial = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[SQ_W-1:0];
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  function automatic arn_root_t root_stage(arn_root_t s, int unsigned stage);
    arn_root_t r;
    r = s;
    for (int unsigned j = 0; j < STEPS_PER_STAGE; j++) begin
      r = root_step(r, stage * STEPS_PER_STAGE + j);
    end
    return r;
  endfunction

endpackage

### rtl/arn_in_if.sv
interface arn_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [arn_pkg::COORD_W-1:0]   src_x;
  logic signed [arn_pkg::COORD_W-1:0]   src_y;
  logic signed [arn_pkg::COORD_W-1:0]   dst_x;
  logic signed [arn_pkg::COORD_W-1:0]   dst_y;
  logic                                 last_pair;

  modport source (output valid, src_x, src_y, dst_x, dst_y, last_pair, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, last_pair, output ready);
endinterface

### rtl/arn_out_if.sv
interface arn_out_if;
  logic                          valid;
  logic                          ready;
  logic [arn_pkg::COORD_W-1:0]   residual;
  logic                          last_out;

  modport source (output valid, residual, last_out, input ready);
  modport sink   (input valid, residual, last_out, output ready);
endinterface

### rtl/arn_cfg_if.sv
interface arn_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [arn_pkg::CFG_IDX_W-1:0]     index;
  logic [arn_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/affine_residual_norm.sv
// Channel  Dir  Payload                                       Completes on
// in_i     in   src_x, src_y, dst_x, dst_y, last_pair         valid & ready
// cfg_i    in   index (register number), data                 valid & ready
// out_o    out  residual, last_out                            valid & ready
//
// One item is taken per cycle while the queue has room; each result passes
// through the twelve-stage square-root pipeline in the back end.
// Reset returns the matrix to identity and the translation to zero.
// When the output stalls, the back pipeline freezes and the four-entry queue
// keeps absorbing items from the multiplier stage until it is full.
module affine_residual_norm (
  input  logic     clk_i,
  input  logic     rst_ni,
  arn_in_if.sink   in_i,
  arn_cfg_if.sink  cfg_i,
  arn_out_if.source out_o
);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  arn_pkg::arn_pair_t push_data, pop_data;

  arn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  arn_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  arn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

### rtl/arn_front.sv
module arn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  arn_in_if.sink              in_i,
  arn_cfg_if.sink             cfg_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output arn_pkg::arn_pair_t  push_data_o
);

  logic signed [arn_pkg::COEF_W-1:0]  m00_q, m01_q, m10_q, m11_q;
  logic signed [arn_pkg::COORD_W-1:0] shift_x_q, shift_y_q;

  logic signed [arn_pkg::PROD_W-1:0] prod00, prod01, prod10, prod11;
  arn_pkg::arn_pair_t                pair_d, pair_q;
  logic                              f_v_d, f_v_q;
  logic                              in_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m00_q     <= arn_pkg::COEF_ONE;
      m01_q     <= arn_pkg::COEF_ZERO;
      m10_q     <= arn_pkg::COEF_ZERO;
      m11_q     <= arn_pkg::COEF_ONE;
      shift_x_q <= arn_pkg::SHIFT_RST;
      shift_y_q <= arn_pkg::SHIFT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        arn_pkg::CFG_M00:     m00_q     <= cfg_i.data;
        arn_pkg::CFG_M01:     m01_q     <= cfg_i.data;
        arn_pkg::CFG_M10:     m10_q     <= cfg_i.data;
        arn_pkg::CFG_M11:     m11_q     <= cfg_i.data;
        arn_pkg::CFG_SHIFT_X: shift_x_q <= cfg_i.data[arn_pkg::COORD_W-1:0];
        arn_pkg::CFG_SHIFT_Y: shift_y_q <= cfg_i.data[arn_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // The stage frees itself whenever the queue takes its item.
  assign in_i.ready = !f_v_q || push_ready_i;
  assign in_acc     = in_i.valid && in_i.ready;

  assign prod00 = m00_q * in_i.src_x;
  assign prod01 = m01_q * in_i.src_y;
  assign prod10 = m10_q * in_i.src_x;
  assign prod11 = m11_q * in_i.src_y;

  // Dropping the low sixteen bits of a two's complement product floors it.
  always_comb begin
    pair_d.p00  = prod00[arn_pkg::PROD_W-1:arn_pkg::FRAC_W];
    pair_d.p01  = prod01[arn_pkg::PROD_W-1:arn_pkg::FRAC_W];
    pair_d.p10  = prod10[arn_pkg::PROD_W-1:arn_pkg::FRAC_W];
    pair_d.p11  = prod11[arn_pkg::PROD_W-1:arn_pkg::FRAC_W];
    pair_d.ox   = {shift_x_q[arn_pkg::COORD_W-1], shift_x_q}
                - {in_i.dst_x[arn_pkg::COORD_W-1], in_i.dst_x};
    pair_d.oy   = {shift_y_q[arn_pkg::COORD_W-1], shift_y_q}
                - {in_i.dst_y[arn_pkg::COORD_W-1], in_i.dst_y};
    pair_d.last = in_i.last_pair;
  end

  always_comb begin
    if (in_acc) begin
      f_v_d = 1'b1;
    end else if (push_ready_i) begin
      f_v_d = 1'b0;
    end else begin
      f_v_d = f_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pair_q <= pair_d;
    end
  end

  assign push_valid_o = f_v_q;
  assign push_data_o  = pair_q;

endmodule

### rtl/arn_fifo.sv
`include "affine_residual_norm_defines.svh"

module arn_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  arn_pkg::arn_pair_t  push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output arn_pkg::arn_pair_t  pop_data_o
);

  arn_pkg::arn_pair_t                 mem_q [arn_pkg::QUEUE_DEPTH];
  logic [arn_pkg::QPTR_W-1:0]         wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [arn_pkg::QCNT_W-1:0]         count_d, count_q;
  logic                               push, pop;

  assign push_ready_o = count_q != arn_pkg::QCNT_W'(arn_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ARN_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= arn_pkg::QCNT_W'(arn_pkg::QUEUE_DEPTH), "queue fill count beyond depth")
  `ARN_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push && !pop, count_q == arn_pkg::QCNT_W'($past(count_q) + 1'b1), "queue fill count missed a push")

endmodule

### rtl/arn_back.sv
`include "affine_residual_norm_defines.svh"

module arn_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  arn_pkg::arn_pair_t  pop_data_i,
  arn_out_if.source           out_o
);

  localparam int unsigned LastStage = arn_pkg::ROOT_STAGES - 1;

  logic                                 adv;
  logic signed [arn_pkg::SUM_W-1:0]     sum_x, sum_y;
  logic signed [arn_pkg::COORD_W-1:0]   sat_x, sat_y;
  logic [arn_pkg::COORD_W-1:0]          abs_x, abs_y;
  logic [arn_pkg::SQ_W-1:0]             sqr_x, sqr_y;

  logic                                 s0_v_q, s1_v_q, s2_v_q;
  logic                                 s0_last_q, s1_last_q, s2_last_q;
  logic signed [arn_pkg::COORD_W-1:0]   dx_q, dy_q;
  logic [arn_pkg::SQ_W-1:0]             sqx_q, sqy_q, mag_q;

  arn_pkg::arn_root_t                   root_init;
  arn_pkg::arn_root_t                   root_d [arn_pkg::ROOT_STAGES];
  arn_pkg::arn_root_t                   root_q [arn_pkg::ROOT_STAGES];
  logic [arn_pkg::ROOT_STAGES-1:0]      root_v_q, root_last_q;

  logic                                 out_v_q, out_last_q;
  logic [arn_pkg::COORD_W-1:0]          out_res_q;

  // The whole pipeline moves together; it holds only while the result waits.
  assign adv         = !out_v_q || out_o.ready;
  assign pop_ready_o = adv;

  assign sum_x = $signed({{2{pop_data_i.p00[arn_pkg::TERM_W-1]}}, pop_data_i.p00})
               + $signed({{2{pop_data_i.p01[arn_pkg::TERM_W-1]}}, pop_data_i.p01})
               + $signed({{(arn_pkg::SUM_W - arn_pkg::OFS_W){pop_data_i.ox[arn_pkg::OFS_W-1]}},
                          pop_data_i.ox});
  assign sum_y = $signed({{2{pop_data_i.p10[arn_pkg::TERM_W-1]}}, pop_data_i.p10})
               + $signed({{2{pop_data_i.p11[arn_pkg::TERM_W-1]}}, pop_data_i.p11})
               + $signed({{(arn_pkg::SUM_W - arn_pkg::OFS_W){pop_data_i.oy[arn_pkg::OFS_W-1]}},
                          pop_data_i.oy});

  always_comb begin
    if (sum_x > arn_pkg::SAT_MAX) begin
      sat_x = arn_pkg::SAT_MAX[arn_pkg::COORD_W-1:0];
    end else if (sum_x < arn_pkg::SAT_MIN) begin
      sat_x = arn_pkg::SAT_MIN[arn_pkg::COORD_W-1:0];
    end else begin
      sat_x = sum_x[arn_pkg::COORD_W-1:0];
    end
    if (sum_y > arn_pkg::SAT_MAX) begin
      sat_y = arn_pkg::SAT_MAX[arn_pkg::COORD_W-1:0];
    end else if (sum_y < arn_pkg::SAT_MIN) begin
      sat_y = arn_pkg::SAT_MIN[arn_pkg::COORD_W-1:0];
    end else begin
      sat_y = sum_y[arn_pkg::COORD_W-1:0];
    end
  end

  // The most negative value maps to its true magnitude as an unsigned word.
  assign abs_x = dx_q[arn_pkg::COORD_W-1] ? ~dx_q + 1'b1 : dx_q;
  assign abs_y = dy_q[arn_pkg::COORD_W-1] ? ~dy_q + 1'b1 : dy_q;
  assign sqr_x = abs_x * abs_x;
  assign sqr_y = abs_y * abs_y;

  always_comb begin
    root_init.rem  = mag_q;
    root_init.root = '0;
    root_d[0] = arn_pkg::root_stage(root_init, 0);
    for (int unsigned s = 1; s < arn_pkg::ROOT_STAGES; s++) begin
      root_d[s] = arn_pkg::root_stage(root_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      root_v_q <= '0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      s0_v_q   <= pop_valid_i;
      s1_v_q   <= s0_v_q;
      s2_v_q   <= s1_v_q;
      root_v_q <= {root_v_q[arn_pkg::ROOT_STAGES-2:0], s2_v_q};
      out_v_q  <= root_v_q[LastStage];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q        <= sat_x;
      dy_q        <= sat_y;
      s0_last_q   <= pop_data_i.last;
      sqx_q       <= sqr_x;
      sqy_q       <= sqr_y;
      s1_last_q   <= s0_last_q;
      mag_q       <= sqx_q + sqy_q;
      s2_last_q   <= s1_last_q;
      root_q      <= root_d;
      root_last_q <= {root_last_q[arn_pkg::ROOT_STAGES-2:0], s2_last_q};
      out_res_q   <= root_q[LastStage].root[arn_pkg::COORD_W-1:0];
      out_last_q  <= root_last_q[LastStage];
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.residual = out_res_q;
  assign out_o.last_out = out_last_q;

  `ARN_ASSERT_NEXT(a_pop_enters, clk_i, rst_ni, adv, s0_v_q == $past(pop_valid_i), "popped item did not enter the first stage")
  `ARN_ASSERT_NEXT(a_stall_freeze, clk_i, rst_ni, !adv, out_v_q && $stable(root_v_q), "pipeline moved while the result was held")

endmodule
